@@ src/sram_pkg.sv @@
package sram_pkg;

	localparam int MaxBlockBytes = 29;
	localparam int BurstBytes    = MaxBlockBytes + 5;
	localparam int BufAw         = $clog2(MaxBlockBytes);
	localparam int NumCfgRegs    = 2;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_BYTE  = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_MBRD = 2'd2;

	localparam logic [0:0] CFG_SYNC_TIMEOUT  = 1'b0;
	localparam logic [0:0] CFG_REPLY_TIMEOUT = 1'b1;

	localparam logic [7:0] BYTE_FF   = 8'hff;
	localparam logic [7:0] BYTE_SYNC = 8'haa;
	localparam logic [7:0] BYTE_ALT  = 8'h55;
	localparam logic [7:0] BYTE_ACK  = 8'h06;
	localparam logic [7:0] WrongMax  = 8'd200;
	localparam logic [3:0] TmoMax    = 4'd10;

	// one queued input beat
	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  opcode;
		logic [9:0]  address;
		logic [4:0]  length;
		logic [31:0] write_value;
		logic [4:0]  buffer_index;
		logic [7:0]  buffer_byte;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  byte_out;
		logic        ok;
		logic [31:0] read_value;
		logic [4:0]  read_count;
		logic        last;
	} result_t;

endpackage

@@ src/serial_register_access_master.sv @@
// A transmit or completion beat is registered from the emit state set when the
// input beat is accepted; a multibyte read data beat is registered directly from it.
// One result beat per cycle while pop keeps the output moving; the engine takes no
// new item until its last result is emitted (longest: 34 bytes 0xFF then 0xAA).
// A two-entry input queue accepts beats while the engine is busy.
// Reset (arst_n low, asynchronous) clears control state; the write buffer
// holds no reset value.
module serial_register_access_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [2:0]  opcode,
	input  logic [9:0]  address,
	input  logic [4:0]  length,
	input  logic [31:0] write_value,
	input  logic [4:0]  buffer_index,
	input  logic [7:0]  buffer_byte,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  byte_out,
	output logic        ok,
	output logic [31:0] read_value,
	output logic [4:0]  read_count,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	sram_pkg::item_t   in_item, item;
	sram_pkg::result_t res;
	logic item_valid, item_take, res_valid;

	assign in_item = '{operation, opcode, address, length, write_value,
	                   buffer_index, buffer_byte, rx_byte};

	sram_front u_front (.clk, .arst_n, .push, .full, .in_item,
		.item_valid, .item_take, .item);

	sram_engine u_engine (.clk, .arst_n, .item_valid, .item_take, .item,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.res_valid, .res_ready(pop), .res);

	assign empty      = !res_valid;
	assign kind       = res.kind;
	assign byte_out   = res.byte_out;
	assign ok         = res.ok;
	assign read_value = res.read_value;
	assign read_count = res.read_count;
	assign last       = res.last;
endmodule

@@ src/sram_front.sv @@
// Input queue: takes beats, holds them until the engine is free.
module sram_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  sram_pkg::item_t     in_item,
	output logic                item_valid,
	input  logic                item_take,
	output sram_pkg::item_t     item
);
	sram_pkg::item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full       = cnt_q == 2'd2;
	assign item_valid = cnt_q != 2'd0;
	assign item       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (item_take && item_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(item_take && item_valid);
		end
	end
endmodule

@@ src/sram_engine.sv @@
// Protocol engine: one item at a time, emits one result per cycle while res_ready allows.
module sram_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_take,
	input  sram_pkg::item_t     item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                res_valid,
	input  logic                res_ready,
	output sram_pkg::result_t   res
);
	typedef enum logic [2:0] {
		PH_IDLE, PH_SYNC, PH_REPLY, PH_DATA, PH_MBLEN, PH_MBDATA
	} phase_t;

	typedef enum logic [2:0] {
		EM_NONE, EM_BURST, EM_AA, EM_HDR0, EM_HDR1, EM_LEN, EM_DATA, EM_DONE
	} emit_t;

	phase_t phase_q;
	emit_t  em_q;
	logic   synced_q, burst_q;
	logic [3:0]  tmo_q;
	logic [7:0]  wrong_q;
	logic [15:0] timer_q, sync_to_q, reply_to_q;
	logic [2:0]  opc_q;
	logic [9:0]  addr_q;
	logic [4:0]  plen_q, bcnt_q;
	logic [5:0]  ecnt_q;
	logic [31:0] shift_q;
	logic [7:0]  wbuf [sram_pkg::MaxBlockBytes];
	logic [7:0]  rd_q;
	logic [4:0]  rd_addr;
	logic        done_ok_q;
	logic [31:0] done_val_q;
	logic [4:0]  done_cnt_q;

	assign cfg_ready = 1'b1;
	// the last beat of an item may leave while the next item is taken
	assign item_take = em_q == EM_NONE && (!res_valid || res_ready);

	// buffer read address runs one entry ahead of the data beat, so rd_q holds it in time
	assign rd_addr = (em_q == EM_DATA && (!res_valid || res_ready)) ?
	                 5'(ecnt_q + 6'd1) : ecnt_q[4:0];

	always_ff @(posedge clk) begin
		if (item_take && item_valid && item.operation == sram_pkg::OP_LOAD &&
		    item.buffer_index < 5'(sram_pkg::MaxBlockBytes))
			wbuf[item.buffer_index[sram_pkg::BufAw-1:0]] <= item.buffer_byte;
		rd_q <= wbuf[rd_addr[sram_pkg::BufAw-1:0]];
	end

	logic [15:0] lim, tnext;
	logic        expired;
	always_comb begin
		lim = (phase_q == PH_SYNC) ? sync_to_q : reply_to_q;
		if (lim == 16'd0) lim = 16'd1;
		tnext   = timer_q + 16'd1;
		expired = tnext >= lim;
	end

	logic [2:0] width;
	assign width = opc_q == 3'd0 ? 3'd1 : (opc_q == 3'd1 ? 3'd2 : 3'd4);
	logic [7:0] fail_val;
	assign fail_val = opc_q < 3'd3 ? 8'hff : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; em_q <= EM_NONE; synced_q <= 1'b0; burst_q <= 1'b1;
			tmo_q <= '0; wrong_q <= '0; timer_q <= '0; opc_q <= '0; addr_q <= '0;
			plen_q <= '0; bcnt_q <= '0; ecnt_q <= '0; shift_q <= '0;
			sync_to_q <= 16'd250; reply_to_q <= 16'd5000;
			res_valid <= 1'b0; res <= '0;
			done_ok_q <= 1'b0; done_val_q <= '0; done_cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == sram_pkg::CFG_SYNC_TIMEOUT) sync_to_q <= cfg_data;
				else reply_to_q <= cfg_data;
			end
			if (res_valid && res_ready) res_valid <= 1'b0;
			if (em_q != EM_NONE && (!res_valid || res_ready)) begin
				res_valid <= 1'b1;
				res <= '0;
				res.kind <= sram_pkg::KIND_TX;
				case (em_q)
				EM_BURST: begin
					res.byte_out <= sram_pkg::BYTE_FF;
					ecnt_q <= ecnt_q + 6'd1;
					if (ecnt_q == 6'(sram_pkg::BurstBytes - 1)) em_q <= EM_AA;
				end
				EM_AA: begin
					res.byte_out <= sram_pkg::BYTE_SYNC;
					res.last <= 1'b1;
					em_q <= EM_NONE;
				end
				EM_HDR0: begin
					res.byte_out <= {3'b000, opc_q, addr_q[9:8]};
					em_q <= EM_HDR1;
				end
				EM_HDR1: begin
					res.byte_out <= addr_q[7:0];
					ecnt_q <= '0;
					if (opc_q == 3'd7) em_q <= EM_LEN;
					else if (opc_q >= 3'd4) em_q <= EM_DATA;
					else begin res.last <= 1'b1; em_q <= EM_NONE; end
				end
				EM_LEN: begin
					res.byte_out <= {3'b000, plen_q};
					if (plen_q == 5'd0) begin res.last <= 1'b1; em_q <= EM_NONE; end
					else em_q <= EM_DATA;
				end
				EM_DATA: begin
					res.byte_out <= (opc_q == 3'd7) ? rd_q : shift_q[7:0];
					shift_q <= shift_q >> 8;
					ecnt_q <= ecnt_q + 6'd1;
					if (ecnt_q + 6'd1 >= {1'b0, plen_q}) begin
						res.last <= 1'b1; em_q <= EM_NONE;
					end
				end
				default: begin
					res.kind <= sram_pkg::KIND_DONE;
					res.ok <= done_ok_q;
					res.read_value <= done_val_q;
					res.read_count <= done_cnt_q;
					res.last <= 1'b1;
					em_q <= EM_NONE;
				end
				endcase
			end

			if (item_take && item_valid) begin
				case (item.operation)
				sram_pkg::OP_START: if (phase_q == PH_IDLE) begin
					opc_q <= item.opcode; addr_q <= item.address;
					shift_q <= (item.opcode >= 3'd4 && item.opcode != 3'd7) ?
					           item.write_value : 32'd0;
					case (item.opcode)
					3'd4: plen_q <= 5'd1;
					3'd5: plen_q <= 5'd2;
					3'd6: plen_q <= 5'd4;
					3'd7: plen_q <= item.length > 5'(sram_pkg::MaxBlockBytes) ?
					                5'(sram_pkg::MaxBlockBytes) : item.length;
					default: plen_q <= 5'd0;
					endcase
					timer_q <= '0;
					if (synced_q) begin
						phase_q <= PH_REPLY; em_q <= EM_HDR0;
					end else begin
						phase_q <= PH_SYNC; tmo_q <= '0; wrong_q <= '0; ecnt_q <= '0;
						em_q <= burst_q ? EM_BURST : EM_AA;
						burst_q <= 1'b0;
					end
				end
				sram_pkg::OP_BYTE: if (phase_q != PH_IDLE) begin
					timer_q <= '0;
					case (phase_q)
					PH_SYNC:
						if (item.rx_byte == sram_pkg::BYTE_SYNC ||
						    item.rx_byte == sram_pkg::BYTE_ALT) begin
							synced_q <= 1'b1; phase_q <= PH_REPLY; em_q <= EM_HDR0;
						end else begin
							wrong_q <= wrong_q + 8'd1;
							if (wrong_q + 8'd1 > sram_pkg::WrongMax) begin
								phase_q <= PH_IDLE; em_q <= EM_DONE; done_ok_q <= 1'b0;
								done_val_q <= {24'd0, fail_val}; done_cnt_q <= '0;
							end
						end
					PH_REPLY: begin
						done_cnt_q <= '0;
						if (item.rx_byte != sram_pkg::BYTE_ACK) begin
							if (item.rx_byte == sram_pkg::BYTE_FF) synced_q <= 1'b0;
							phase_q <= PH_IDLE; em_q <= EM_DONE; done_ok_q <= 1'b0;
							done_val_q <= {24'd0, fail_val};
						end else if (opc_q >= 3'd4) begin
							phase_q <= PH_IDLE; em_q <= EM_DONE; done_ok_q <= 1'b1;
							done_val_q <= '0;
						end else if (opc_q == 3'd3) phase_q <= PH_MBLEN;
						else begin
							phase_q <= PH_DATA; bcnt_q <= '0; shift_q <= '0;
						end
					end
					PH_DATA: begin
						bcnt_q <= bcnt_q + 5'd1;
						if (bcnt_q + 5'd1 >= {2'b00, width}) begin
							phase_q <= PH_IDLE; em_q <= EM_DONE; done_ok_q <= 1'b1;
							done_cnt_q <= '0;
							done_val_q <= shift_q | ({24'd0, item.rx_byte} << {bcnt_q[1:0], 3'b000});
						end else
							shift_q <= shift_q | ({24'd0, item.rx_byte} << {bcnt_q[1:0], 3'b000});
					end
					PH_MBLEN: begin
						done_val_q <= '0; done_cnt_q <= '0;
						if (item.rx_byte > 8'(sram_pkg::MaxBlockBytes)) begin
							phase_q <= PH_IDLE; em_q <= EM_DONE; done_ok_q <= 1'b0;
						end else if (item.rx_byte == 8'd0) begin
							phase_q <= PH_IDLE; em_q <= EM_DONE; done_ok_q <= 1'b1;
						end else begin
							plen_q <= item.rx_byte[4:0]; bcnt_q <= '0; phase_q <= PH_MBDATA;
						end
					end
					default: begin
						res_valid <= 1'b1;
						res <= '0;
						res.kind <= sram_pkg::KIND_MBRD;
						res.byte_out <= item.rx_byte;
						bcnt_q <= bcnt_q + 5'd1;
						if (bcnt_q + 5'd1 >= plen_q) begin
							phase_q <= PH_IDLE; em_q <= EM_DONE; done_ok_q <= 1'b1;
							done_val_q <= '0; done_cnt_q <= plen_q;
						end else res.last <= 1'b1;
					end
					endcase
				end
				sram_pkg::OP_TICK: if (phase_q != PH_IDLE) begin
					timer_q <= expired ? 16'd0 : tnext;
					if (expired) begin
						done_ok_q <= 1'b0; done_cnt_q <= '0;
						case (phase_q)
						PH_SYNC: begin
							tmo_q <= tmo_q + 4'd1;
							wrong_q <= wrong_q + 8'd1;
							if (tmo_q + 4'd1 > sram_pkg::TmoMax ||
							    wrong_q + 8'd1 > sram_pkg::WrongMax) begin
								phase_q <= PH_IDLE; em_q <= EM_DONE;
								done_val_q <= {24'd0, fail_val};
							end
						end
						PH_REPLY: begin
							synced_q <= 1'b0; phase_q <= PH_IDLE; em_q <= EM_DONE;
							done_val_q <= {24'd0, fail_val};
						end
						PH_DATA: begin
							phase_q <= PH_IDLE; em_q <= EM_DONE;
							done_val_q <= opc_q == 3'd0 ? 32'hff :
							              (opc_q == 3'd1 ? 32'hffff : 32'hffffffff);
						end
						PH_MBLEN: begin
							phase_q <= PH_IDLE; em_q <= EM_DONE; done_val_q <= '0;
						end
						default: begin
							phase_q <= PH_IDLE; em_q <= EM_DONE; done_val_q <= '0;
							done_cnt_q <= plen_q;
						end
						endcase
					end
				end
				default: ;
				endcase
			end
		end
	end

	ap_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> em_q == EM_NONE) else $error("take while emitting");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid) else $error("result dropped");
	ap_burst_once: assert property (@(posedge clk) disable iff (!arst_n)
		em_q == EM_BURST |-> !burst_q) else $error("burst repeated");
endmodule

@@ dv/serial_register_access_master_tb.sv @@
`timescale 1ns / 100ps

module serial_register_access_master_tb;

	// link protocol phases, as tracked by the predictor
	typedef enum logic [2:0] {
		ST_IDLE, ST_SYNC, ST_REPLY, ST_DATA, ST_MBLEN, ST_MBDATA
	} link_phase_e;

	localparam logic [2:0] OPC_RD8  = 3'd0;
	localparam logic [2:0] OPC_RD16 = 3'd1;
	localparam logic [2:0] OPC_RD32 = 3'd2;
	localparam logic [2:0] OPC_RDMB = 3'd3;
	localparam logic [2:0] OPC_WR8  = 3'd4;
	localparam logic [2:0] OPC_WR16 = 3'd5;
	localparam logic [2:0] OPC_WR32 = 3'd6;
	localparam logic [2:0] OPC_WRMB = 3'd7;

	// Predicts the beats the master emits and checks them in order.
	class link_scoreboard;
		logic [15:0] sync_limit = 16'd250;
		logic [15:0] reply_limit = 16'd5000;
		link_phase_e phase = ST_IDLE;
		bit          synced = 0;
		bit          burst_due = 1;
		logic [3:0]  tmo_cnt = 0;
		logic [7:0]  wrong_cnt = 0;
		logic [15:0] timer = 0;
		logic [2:0]  opc = 0;
		logic [9:0]  addr = 0;
		logic [4:0]  len = 0;
		logic [31:0] shreg = 0;
		logic [4:0]  cnt = 0;
		logic [7:0]  wbuf [sram_pkg::MaxBlockBytes];
		sram_pkg::result_t beats [$];
		sram_pkg::result_t expected_beats [$];
		int          mismatches = 0;

		function void set_reg(logic [0:0] idx, logic [15:0] val);
			if (idx == sram_pkg::CFG_SYNC_TIMEOUT) sync_limit = val;
			else reply_limit = val;
		endfunction

		function void emit(logic [1:0] k, logic [7:0] b, logic o, logic [31:0] v,
				logic [4:0] c);
			sram_pkg::result_t r;
			r.kind = k;
			r.byte_out = b;
			r.ok = o;
			r.read_value = v;
			r.read_count = c;
			r.last = 1'b0;
			beats.push_back(r);
		endfunction

		function bit expired(logic [15:0] lim);
			logic [15:0] l;
			l = (lim == 0) ? 16'd1 : lim;
			timer = timer + 16'd1;
			if (timer >= l) begin
				timer = 0;
				return 1;
			end
			return 0;
		endfunction

		function void complete(logic o, logic [31:0] v, logic [4:0] c);
			emit(sram_pkg::KIND_DONE, 8'h00, o, v, c);
			phase = ST_IDLE;
		endfunction

		// failure before any data; 8/16/32-bit reads report 0xFF
		function void fail_early();
			complete(1'b0, (opc < OPC_RDMB) ? 32'hff : 32'h0, 5'd0);
		endfunction

		function void send_frame();
			int i;
			emit(sram_pkg::KIND_TX, {opc, addr[9:8]}, 0, 0, 0);
			emit(sram_pkg::KIND_TX, addr[7:0], 0, 0, 0);
			if (opc == OPC_WRMB) begin
				emit(sram_pkg::KIND_TX, {3'b000, len}, 0, 0, 0);
				for (i = 0; i < len; i++) emit(sram_pkg::KIND_TX, wbuf[i], 0, 0, 0);
			end else if (opc >= OPC_WR8) begin
				for (i = 0; i < len && i < 4; i++)
					emit(sram_pkg::KIND_TX, shreg[8*i +: 8], 0, 0, 0);
			end
			phase = ST_REPLY;
			timer = 0;
		endfunction

		function void on_start(sram_pkg::item_t it);
			int i;
			if (phase != ST_IDLE) return;
			opc = it.opcode;
			addr = it.address;
			shreg = 0;
			case (opc)
				OPC_WR8: begin len = 1; shreg = it.write_value; end
				OPC_WR16: begin len = 2; shreg = it.write_value; end
				OPC_WR32: begin len = 4; shreg = it.write_value; end
				OPC_WRMB: len = (it.length > sram_pkg::MaxBlockBytes) ?
					5'(sram_pkg::MaxBlockBytes) : it.length;
				default: len = 0;
			endcase
			if (synced) begin
				send_frame();
				return;
			end
			if (burst_due) begin
				for (i = 0; i < sram_pkg::BurstBytes; i++)
					emit(sram_pkg::KIND_TX, sram_pkg::BYTE_FF, 0, 0, 0);
				burst_due = 0;
			end
			emit(sram_pkg::KIND_TX, sram_pkg::BYTE_SYNC, 0, 0, 0);
			phase = ST_SYNC;
			timer = 0;
			tmo_cnt = 0;
			wrong_cnt = 0;
		endfunction

		function void on_byte(logic [7:0] b);
			int w;
			if (phase == ST_IDLE) return;
			timer = 0;
			case (phase)
				ST_SYNC: begin
					if (b == sram_pkg::BYTE_SYNC || b == sram_pkg::BYTE_ALT) begin
						synced = 1;
						send_frame();
					end else begin
						wrong_cnt++;
						if (wrong_cnt > sram_pkg::WrongMax) fail_early();
					end
				end
				ST_REPLY: begin
					if (b == sram_pkg::BYTE_FF) begin
						synced = 0;
						fail_early();
					end else if (b != sram_pkg::BYTE_ACK) fail_early();
					else if (opc >= OPC_WR8) complete(1'b1, 0, 0);
					else if (opc == OPC_RDMB) phase = ST_MBLEN;
					else begin
						phase = ST_DATA;
						cnt = 0;
						shreg = 0;
					end
				end
				ST_DATA: begin
					w = (opc == OPC_RD8) ? 1 : (opc == OPC_RD16) ? 2 : 4;
					if (cnt < 4) shreg[8*cnt +: 8] = b;
					cnt++;
					if (cnt >= w) complete(1'b1, shreg, 0);
				end
				ST_MBLEN: begin
					if (b > sram_pkg::MaxBlockBytes) complete(1'b0, 0, 0);
					else if (b == 0) complete(1'b1, 0, 0);
					else begin
						len = b[4:0];
						cnt = 0;
						phase = ST_MBDATA;
					end
				end
				default: begin
					emit(sram_pkg::KIND_MBRD, b, 0, 0, 0);
					cnt++;
					if (cnt >= len) complete(1'b1, 0, len);
				end
			endcase
		endfunction

		function void on_tick();
			case (phase)
				ST_SYNC: begin
					if (!expired(sync_limit)) return;
					tmo_cnt++;
					if (tmo_cnt > sram_pkg::TmoMax) begin
						fail_early();
						return;
					end
					wrong_cnt++;
					if (wrong_cnt > sram_pkg::WrongMax) fail_early();
				end
				ST_REPLY: if (expired(reply_limit)) begin
					synced = 0;
					fail_early();
				end
				ST_DATA: if (expired(reply_limit))
					complete(1'b0, (opc == OPC_RD8) ? 32'hff :
						(opc == OPC_RD16) ? 32'hffff : 32'hffff_ffff, 0);
				ST_MBLEN: if (expired(reply_limit)) complete(1'b0, 0, 0);
				ST_MBDATA: if (expired(reply_limit)) complete(1'b0, 0, len);
				default: ;
			endcase
		endfunction

		function void note_input(sram_pkg::item_t it);
			beats.delete();
			case (it.operation)
				sram_pkg::OP_START: on_start(it);
				sram_pkg::OP_LOAD:
					if (it.buffer_index < sram_pkg::MaxBlockBytes)
						wbuf[it.buffer_index] = it.buffer_byte;
				sram_pkg::OP_BYTE: on_byte(it.rx_byte);
				default: on_tick();
			endcase
			if (beats.size() > 0) beats[beats.size()-1].last = 1'b1;
			foreach (beats[i]) expected_beats.push_back(beats[i]);
		endfunction

		function void check_result(sram_pkg::result_t act);
			sram_pkg::result_t exp_r;
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t unexpected beat kind=%0d byte=%h", $realtime, act.kind,
						act.byte_out);
				return;
			end
			exp_r = expected_beats.pop_front();
			if (exp_r !== act) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t mismatch exp k=%0d b=%h ok=%0d v=%h c=%0d l=%0d",
						" act k=%0d b=%h ok=%0d v=%h c=%0d l=%0d"},
						$realtime, exp_r.kind, exp_r.byte_out, exp_r.ok, exp_r.read_value,
						exp_r.read_count, exp_r.last, act.kind, act.byte_out, act.ok,
						act.read_value, act.read_count, act.last);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  operation;
	logic [2:0]  opcode;
	logic [9:0]  address;
	logic [4:0]  length;
	logic [31:0] write_value;
	logic [4:0]  buffer_index;
	logic [7:0]  buffer_byte;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic [1:0]  kind;
	logic [7:0]  byte_out;
	logic        ok;
	logic [31:0] read_value;
	logic [4:0]  read_count;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	link_scoreboard sb = new();
	bit      calm = 0;       // no idling on either side when set
	int      pop_hold = 0;
	sram_pkg::result_t seen;

	serial_register_access_master dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side: check on every accepted beat, stall in short random bursts
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			seen.kind = kind;
			seen.byte_out = byte_out;
			seen.ok = ok;
			seen.read_value = read_value;
			seen.read_count = read_count;
			seen.last = last;
			sb.check_result(seen);
		end
		if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			pop_hold = $urandom_range(0, 2);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	function automatic sram_pkg::item_t rand_item();
		sram_pkg::item_t it;
		it.operation = 2'($urandom_range(0, 3));
		it.opcode = 3'($urandom_range(0, 7));
		it.address = 10'($urandom_range(0, 1023));
		it.length = 5'($urandom_range(0, 31));
		it.write_value = $urandom();
		it.buffer_index = 5'($urandom_range(0, 31));
		it.buffer_byte = 8'($urandom_range(0, 255));
		it.rx_byte = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic sram_pkg::item_t req(logic [2:0] opc, logic [4:0] len);
		sram_pkg::item_t it;
		it = rand_item();
		it.operation = sram_pkg::OP_START;
		it.opcode = opc;
		it.length = len;
		return it;
	endfunction

	function automatic sram_pkg::item_t rx(logic [7:0] b);
		sram_pkg::item_t it;
		it = rand_item();
		it.operation = sram_pkg::OP_BYTE;
		it.rx_byte = b;
		return it;
	endfunction

	function automatic sram_pkg::item_t tick_beat();
		sram_pkg::item_t it;
		it = rand_item();
		it.operation = sram_pkg::OP_TICK;
		return it;
	endfunction

	function automatic sram_pkg::item_t load(logic [4:0] idx);
		sram_pkg::item_t it;
		it = rand_item();
		it.operation = sram_pkg::OP_LOAD;
		it.buffer_index = idx;
		return it;
	endfunction

	// push stays high across back-to-back beats; callers lower it before waiting
	task automatic push_beat(input sram_pkg::item_t it);
		operation <= it.operation;
		opcode <= it.opcode;
		address <= it.address;
		length <= it.length;
		write_value <= it.write_value;
		buffer_index <= it.buffer_index;
		buffer_byte <= it.buffer_byte;
		rx_byte <= it.rx_byte;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_input(it);
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// hold off until every expected beat is out, then let queued no-result beats drain
	task automatic settle_idle();
		int guard;
		push <= 1'b0;
		guard = 0;
		while (sb.expected_beats.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
	endtask

	// drive the open request to its end with bytes, so ticks are not needed
	task automatic close_request();
		while (sb.phase != ST_IDLE) begin
			case (sb.phase)
				ST_SYNC: push_beat(rx(sram_pkg::BYTE_ALT));
				ST_REPLY: push_beat(rx(8'h33));
				ST_MBLEN: push_beat(rx(8'h00));
				default: push_beat(rx(8'($urandom_range(0, 255))));
			endcase
		end
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
		settle_idle();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	// one random beat steered by the predicted phase; counted is 0 when it is ignored, save a start while busy
	task automatic random_beat(output bit counted);
		sram_pkg::item_t it;
		int r;
		it = rand_item();
		r = $urandom_range(0, 99);
		counted = 1;
		case (sb.phase)
			ST_IDLE: begin
				if (r < 70) begin
					it.operation = sram_pkg::OP_START;
					if (it.opcode == OPC_WRMB && r < 55) it.length = 5'($urandom_range(0, 8));
				end else if (r < 90) begin
					it.operation = sram_pkg::OP_LOAD;
					counted = it.buffer_index < sram_pkg::MaxBlockBytes;
				end else begin
					counted = (it.operation == sram_pkg::OP_START) ||
						(it.operation == sram_pkg::OP_LOAD &&
						 it.buffer_index < sram_pkg::MaxBlockBytes);
				end
			end
			ST_SYNC: begin
				it.operation = (r < 85) ? sram_pkg::OP_BYTE : sram_pkg::OP_TICK;
				if (r < 65) it.rx_byte = (r < 35) ? sram_pkg::BYTE_SYNC : sram_pkg::BYTE_ALT;
			end
			ST_REPLY: begin
				it.operation = (r < 90) ? sram_pkg::OP_BYTE : sram_pkg::OP_TICK;
				if (r < 70) it.rx_byte = sram_pkg::BYTE_ACK;
				else if (r < 78) it.rx_byte = sram_pkg::BYTE_FF;
			end
			ST_MBLEN: begin
				it.operation = (r < 92) ? sram_pkg::OP_BYTE : sram_pkg::OP_TICK;
				if (r < 80) it.rx_byte = 8'($urandom_range(0, 6));
			end
			default: begin
				if (r >= 92) it.operation = sram_pkg::OP_TICK;
				else if (r >= 4) it.operation = sram_pkg::OP_BYTE;
				else counted = it.operation != sram_pkg::OP_LOAD ||
					it.buffer_index < sram_pkg::MaxBlockBytes;
			end
		endcase
		push_beat(it);
	endtask

	task automatic random_phase(input int n);
		int done;
		bit c;
		done = 0;
		while (done < n) begin
			random_beat(c);
			if (c) done++;
		end
		close_request();
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		operation = sram_pkg::OP_TICK;
		opcode = '0;
		address = '0;
		length = '0;
		write_value = '0;
		buffer_index = '0;
		buffer_byte = '0;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = sram_pkg::CFG_SYNC_TIMEOUT;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero sync limit behaves as one tick; short reply limit
		write_reg(sram_pkg::CFG_SYNC_TIMEOUT, 16'd0);
		write_reg(sram_pkg::CFG_REPLY_TIMEOUT, 16'd2);

		// fill the whole write buffer so no multibyte write sends an unloaded entry
		for (i = 0; i < sram_pkg::MaxBlockBytes; i++) push_beat(load(5'(i)));

		// directed: out-of-range loads, stray beats, then each protocol corner
		push_beat(load(5'd29));
		push_beat(load(5'd31));
		push_beat(rx(sram_pkg::BYTE_ACK));
		push_beat(tick_beat());
		push_beat(req(OPC_RD8, 5'd0));             // 0xFF burst then 0xAA
		for (i = 0; i < 11; i++) push_beat(tick_beat()); // too many sync timeouts
		push_beat(req(OPC_WR16, 5'd31));
		push_beat(req(OPC_RD8, 5'd0));             // start while busy: dropped
		push_beat(rx(sram_pkg::BYTE_ALT));
		push_beat(rx(sram_pkg::BYTE_ACK));
		push_beat(req(OPC_RD32, 5'd0));
		push_beat(rx(sram_pkg::BYTE_ACK));
		for (i = 0; i < 4; i++) push_beat(rx(8'($urandom_range(0, 255))));
		push_beat(req(OPC_RD16, 5'd0));
		push_beat(rx(sram_pkg::BYTE_ACK));
		push_beat(rx(8'h5a));
		push_beat(tick_beat());
		push_beat(tick_beat());                    // data timeout, all ones
		push_beat(req(OPC_RDMB, 5'd0));
		push_beat(rx(sram_pkg::BYTE_ACK));
		push_beat(rx(8'd3));
		for (i = 0; i < 3; i++) push_beat(rx(8'($urandom_range(0, 255))));
		push_beat(req(OPC_RDMB, 5'd0));
		push_beat(rx(sram_pkg::BYTE_ACK));
		push_beat(rx(8'd30));                      // oversized length
		push_beat(req(OPC_RDMB, 5'd0));
		push_beat(rx(sram_pkg::BYTE_ACK));
		push_beat(rx(8'd0));                       // zero length
		push_beat(req(OPC_RDMB, 5'd0));
		push_beat(rx(sram_pkg::BYTE_ACK));
		push_beat(rx(8'd29));
		push_beat(rx(8'hc3));
		push_beat(tick_beat());
		push_beat(tick_beat());                    // timeout mid-block
		push_beat(req(OPC_WRMB, 5'd31));           // length saturates
		push_beat(rx(8'h12));                      // NAK, link stays synced
		push_beat(req(OPC_WR8, 5'd0));
		push_beat(rx(sram_pkg::BYTE_FF));          // 0xFF reply drops sync
		push_beat(req(OPC_RDMB, 5'd0));
		push_beat(rx(sram_pkg::BYTE_SYNC));
		push_beat(tick_beat());
		push_beat(tick_beat());                    // reply timeout drops sync
		push_beat(req(OPC_RDMB, 5'd0));
		push_beat(rx(sram_pkg::BYTE_SYNC));
		push_beat(rx(sram_pkg::BYTE_ACK));
		push_beat(tick_beat());
		push_beat(tick_beat());                    // length byte timeout

		// random part over several timeout settings; the last one runs without idling
		random_phase(6);
		write_reg(sram_pkg::CFG_SYNC_TIMEOUT, 16'hffff);
		write_reg(sram_pkg::CFG_REPLY_TIMEOUT, 16'hffff);
		random_phase(6);
		write_reg(sram_pkg::CFG_SYNC_TIMEOUT, 16'd3);
		write_reg(sram_pkg::CFG_REPLY_TIMEOUT, 16'd1);
		random_phase(6);
		write_reg(sram_pkg::CFG_SYNC_TIMEOUT, 16'($urandom_range(1, 6)));
		write_reg(sram_pkg::CFG_REPLY_TIMEOUT, 16'($urandom_range(1, 6)));
		calm = 1;
		random_phase(6);

		settle_idle();
		if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
			$display("== PASS ==");
		end else begin
			if (sb.expected_beats.size() != 0)
				$display("%0d expected beats never arrived", sb.expected_beats.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/sram_pkg.sv
src/sram_front.sv
src/sram_engine.sv
src/serial_register_access_master.sv
dv/serial_register_access_master_tb.sv
